### hw/rtl/xcsfd_pkg.sv
// ----------------------------------------------------------------------------
// xcsfd_pkg
// Shared types, constants and tables of the XOR-checked sensor frame decoder.
// ----------------------------------------------------------------------------
package xcsfd_pkg;

  localparam int unsigned FRAME_BUFFER_BYTES = 128;
  localparam int unsigned FRACTION_BITS      = 12;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_LEFT_BIAS   = 3'd0;
  localparam logic [2:0] CFG_RIGHT_BIAS  = 3'd1;
  localparam logic [2:0] CFG_LEFT_SCALE  = 3'd2;
  localparam logic [2:0] CFG_RIGHT_SCALE = 3'd3;
  localparam logic [2:0] CFG_ANGLE_SCALE = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // characters
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;

  // table ranges
  localparam int LEFT_LOW    = 541;
  localparam int LEFT_HIGH   = 766;
  localparam int RIGHT_LOW   = 588;
  localparam int RIGHT_HIGH  = 763;
  localparam int ANGLE_LIMIT = 800;
  localparam int MAX_ACC     = 32768;

  typedef struct packed {
    logic signed [7:0]  left_bias;
    logic signed [7:0]  right_bias;
    logic signed [15:0] left_scale;
    logic signed [15:0] right_scale;
    logic signed [15:0] angle_scale;
  } cfg_t;

  // one finished line handed from parser to arithmetic
  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] frame_id;
    logic signed [15:0] left_reading;
    logic signed [15:0] right_reading;
  } job_t;

  localparam logic [6:0] LEFT_ROM [0:LEFT_HIGH-LEFT_LOW-1] = '{
    7'd100,7'd95,7'd93,7'd90,7'd85,7'd83,7'd80,7'd78,7'd77,7'd75,
    7'd74,7'd73,7'd71,7'd70,7'd69,7'd68,7'd68,7'd67,7'd66,7'd65,
    7'd64,7'd64,7'd63,7'd63,7'd62,7'd61,7'd61,7'd60,7'd60,7'd59,
    7'd59,7'd58,7'd58,7'd58,7'd57,7'd57,7'd56,7'd56,7'd55,7'd55,
    7'd55,7'd55,7'd54,7'd54,7'd54,7'd54,7'd53,7'd53,7'd53,7'd53,
    7'd52,7'd52,7'd52,7'd52,7'd51,7'd51,7'd51,7'd51,7'd50,7'd50,
    7'd50,7'd49,7'd49,7'd49,7'd49,7'd48,7'd48,7'd48,7'd48,7'd47,
    7'd47,7'd47,7'd46,7'd46,7'd46,7'd46,
    7'd45,7'd45,7'd45,7'd45,7'd45,7'd45,
    7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,
    7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,
    7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,
    7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,
    7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,
    7'd40,7'd40,7'd40,7'd40,
    7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,
    7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,
    7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,
    7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,
    7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,
    7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,
    7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,
    7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,
    7'd35,7'd35,7'd35,7'd35,7'd35,7'd35,7'd35,7'd35,7'd35
  };

  localparam logic [6:0] RIGHT_ROM [0:RIGHT_HIGH-RIGHT_LOW-1] = '{
    7'd95,7'd90,7'd85,7'd80,7'd75,7'd70,7'd65,7'd60,7'd55,7'd55,
    7'd54,7'd54,7'd54,7'd54,7'd50,7'd50,7'd50,7'd50,7'd50,
    7'd49,7'd49,7'd49,7'd49,7'd49,7'd49,7'd49,7'd49,
    7'd48,7'd48,7'd48,7'd48,7'd48,7'd48,7'd48,7'd48,7'd48,
    7'd47,7'd47,7'd47,7'd47,7'd47,7'd47,7'd47,7'd47,
    7'd46,7'd46,7'd46,7'd46,7'd46,7'd46,7'd46,7'd46,
    7'd45,7'd45,7'd45,7'd45,7'd45,7'd45,7'd45,7'd45,
    7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,7'd44,
    7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,7'd43,
    7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,7'd42,
    7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,7'd41,
    7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,7'd40,
    7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,
    7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,7'd39,
    7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,
    7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,7'd38,
    7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,
    7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,7'd37,
    7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,
    7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,7'd36,
    7'd35,7'd35,7'd35,7'd35,7'd35,7'd35,7'd35,7'd35
  };

endpackage

### hw/rtl/xcsfd_front.sv
// ----------------------------------------------------------------------------
// xcsfd_front
// Byte parser: checksum, hex check value and decimal fields of one line.
// ----------------------------------------------------------------------------
module xcsfd_front #(
  parameter int unsigned FrameBufferBytes = xcsfd_pkg::FRAME_BUFFER_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output xcsfd_pkg::job_t    job_o
);
  import xcsfd_pkg::*;

  localparam logic [10:0] CountMax = 11'd2047;
  localparam logic [10:0] StarLast = 11'(FrameBufferBytes - 7);
  localparam logic [10:0] LineMax  = 11'(FrameBufferBytes);

  logic [10:0]        count_q, count_d;
  logic [7:0]         xor_q, xor_d;
  logic               star_q, star_d;
  logic [7:0]         hex_q, hex_d;
  logic               hex_done_q, hex_done_d;
  logic [2:0]         fidx_q, fidx_d;
  logic [16:0]        acc_q, acc_d;
  logic               act_q, act_d, seen_q, seen_d, neg_q, neg_d;
  logic signed [15:0] pf_q [3];
  logic signed [15:0] pf_d [3];

  logic [10:0]        count_inc;
  logic               is_digit, is_hex;
  logic [3:0]         nib;
  logic [20:0]        acc_mul;
  logic [16:0]        mag;
  logic signed [15:0] commit_val;
  logic               commit_ok;
  logic [1:0]         fsel;
  logic [2:0]         fidx_new;

  // classify the byte
  always_comb begin
    is_digit = rx_byte_i inside {[8'h30:8'h39]};
    is_hex   = 1'b1;
    nib      = 4'd0;
    if (is_digit) begin
      nib = rx_byte_i[3:0];
    end else if (rx_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      nib = 4'(rx_byte_i[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  // value of the open field when it closes
  always_comb begin
    if (acc_q > 17'd32767) begin
      mag = neg_q ? 17'd32768 : 17'd32767;
    end else begin
      mag = acc_q;
    end
    commit_val = neg_q ? 16'(-mag) : mag[15:0];
    commit_ok  = act_q && (fidx_q >= 3'd1) && (fidx_q <= 3'd3);
    fsel       = 2'(fidx_q - 3'd1);
  end

  assign count_inc = (count_q == CountMax) ? count_q : 11'(count_q + 11'd1);
  assign acc_mul   = 21'({acc_q, 3'b000}) + 21'({acc_q, 1'b0}) + 21'(rx_byte_i[3:0]);
  assign fidx_new  = (fidx_q < 3'd7) ? 3'(fidx_q + 3'd1) : fidx_q;

  // next line state
  always_comb begin
    count_d    = count_inc;
    xor_d      = xor_q;
    star_d     = star_q;
    hex_d      = hex_q;
    hex_done_d = hex_done_q;
    fidx_d     = fidx_q;
    acc_d      = acc_q;
    act_d      = act_q;
    seen_d     = seen_q;
    neg_d      = neg_q;
    pf_d       = pf_q;
    push_o     = 1'b0;
    job_o      = '0;

    if (rx_byte_i == CHR_NL) begin
      // close the line and hand it on
      if (commit_ok) begin
        pf_d[fsel] = commit_val;
      end
      push_o              = accept_i;
      job_o.frame_id      = pf_d[0];
      job_o.left_reading  = pf_d[1];
      job_o.right_reading = pf_d[2];
      if (count_inc <= 11'd4) begin
        job_o.status = ST_SHORT;
      end else if (count_inc > LineMax) begin
        job_o.status = ST_CHECKSUM;
      end else if (!star_q || (xor_q != hex_q)) begin
        job_o.status = ST_CHECKSUM;
      end else begin
        job_o.status = ST_OK;
      end
      count_d    = '0;
      xor_d      = '0;
      star_d     = 1'b0;
      hex_d      = '0;
      hex_done_d = 1'b0;
      fidx_d     = '0;
      acc_d      = '0;
      act_d      = 1'b0;
      seen_d     = 1'b0;
      neg_d      = 1'b0;
      pf_d[0]    = '0;
      pf_d[1]    = '0;
      pf_d[2]    = '0;
    end else begin
      // checksum and check value
      if (star_q) begin
        if (!hex_done_q) begin
          if (is_hex) begin
            hex_d = {hex_q[3:0], nib};
          end else begin
            hex_done_d = 1'b1;
          end
        end
      end else if ((count_q >= 11'd1) && (count_q <= StarLast)) begin
        if (rx_byte_i == CHR_STAR) begin
          star_d = 1'b1;
        end else begin
          xor_d = xor_q ^ rx_byte_i;
        end
      end
      // decimal field
      if (act_q) begin
        if (!seen_q && (rx_byte_i == CHR_PLUS || rx_byte_i == CHR_MINUS)) begin
          seen_d = 1'b1;
          neg_d  = (rx_byte_i == CHR_MINUS);
        end else if (is_digit) begin
          seen_d = 1'b1;
          acc_d  = (acc_mul > 21'(MAX_ACC)) ? 17'(MAX_ACC) : acc_mul[16:0];
        end else begin
          if (commit_ok) begin
            pf_d[fsel] = commit_val;
          end
          act_d  = 1'b0;
          seen_d = 1'b0;
          neg_d  = 1'b0;
        end
      end
      // field separator opens the next field
      if (rx_byte_i == CHR_COMMA) begin
        fidx_d = fidx_new;
        if ((fidx_new >= 3'd1) && (fidx_new <= 3'd3)) begin
          acc_d  = '0;
          act_d  = 1'b1;
          seen_d = 1'b0;
          neg_d  = 1'b0;
        end
      end
    end
  end

  // hold line state between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      xor_q      <= '0;
      star_q     <= 1'b0;
      hex_q      <= '0;
      hex_done_q <= 1'b0;
      fidx_q     <= '0;
      acc_q      <= '0;
      act_q      <= 1'b0;
      seen_q     <= 1'b0;
      neg_q      <= 1'b0;
      pf_q[0]    <= '0;
      pf_q[1]    <= '0;
      pf_q[2]    <= '0;
    end else if (accept_i) begin
      count_q    <= count_d;
      xor_q      <= xor_d;
      star_q     <= star_d;
      hex_q      <= hex_d;
      hex_done_q <= hex_done_d;
      fidx_q     <= fidx_d;
      acc_q      <= acc_d;
      act_q      <= act_d;
      seen_q     <= seen_d;
      neg_q      <= neg_d;
      pf_q       <= pf_d;
    end
  end

endmodule

### hw/rtl/xcsfd_queue.sv
// ----------------------------------------------------------------------------
// xcsfd_queue
// Two-entry queue of finished lines between parser and arithmetic.
// ----------------------------------------------------------------------------
module xcsfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xcsfd_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output xcsfd_pkg::job_t job_o
);
  import xcsfd_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  // store entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= 2'(cnt_q + 2'(push_i) - 2'(pop_i));
    end
  end

endmodule

### hw/rtl/xcsfd_back.sv
// ----------------------------------------------------------------------------
// xcsfd_back
// Table lookup, scaling through one shared multiplier, last-good hold and
// the output register.
// ----------------------------------------------------------------------------
module xcsfd_back #(
  parameter int unsigned FractionBits = xcsfd_pkg::FRACTION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xcsfd_pkg::cfg_t     cfg_i,
  input  logic                job_valid_i,
  input  xcsfd_pkg::job_t     job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [15:0]  frame_id_o,
  output logic signed [15:0]  left_reading_o,
  output logic signed [15:0]  right_reading_o,
  output logic signed [15:0]  left_distance_o,
  output logic signed [15:0]  right_distance_o,
  output logic signed [10:0]  steer_angle_o
);
  import xcsfd_pkg::*;

  localparam logic signed [33:0] Half = 34'sd1 <<< (FractionBits - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LMUL   = 7'b0000010,
    S_RMUL   = 7'b0000100,
    S_RCAP   = 7'b0001000,
    S_AMUL   = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  job_t               job_q;
  logic signed [32:0] prod_q;
  logic signed [15:0] dl_q, dr_q;
  logic signed [15:0] lg_q [5];
  logic signed [10:0] lg_angle_q;

  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [33:0] rsum, rsh;
  logic signed [15:0] rsat;
  logic signed [10:0] rclamp;
  logic [7:0]         il, ir;
  logic signed [11:0] sl, sr;
  logic signed [11:0] lo_ext, ro_ext;
  logic               out_free;

  assign out_free = !out_valid_o || out_ready_i;
  assign pop_o    = (state_q == S_IDLE) && job_valid_i;

  // clamp raw readings into table index
  always_comb begin
    if (job_q.left_reading < 16'(LEFT_LOW)) begin
      il = '0;
    end else if (job_q.left_reading >= 16'(LEFT_HIGH)) begin
      il = 8'(LEFT_HIGH - LEFT_LOW - 1);
    end else begin
      il = 8'(job_q.left_reading - 16'(LEFT_LOW));
    end
    if (job_q.right_reading < 16'(RIGHT_LOW)) begin
      ir = '0;
    end else if (job_q.right_reading >= 16'(RIGHT_HIGH)) begin
      ir = 8'(RIGHT_HIGH - RIGHT_LOW - 1);
    end else begin
      ir = 8'(job_q.right_reading - 16'(RIGHT_LOW));
    end
    lo_ext = 12'(cfg_i.left_bias);
    ro_ext = 12'(cfg_i.right_bias);
    sl = $signed({5'b0, LEFT_ROM[il]}) + (lo_ext <<< 3) + (lo_ext <<< 1);
    sr = $signed({5'b0, RIGHT_ROM[ir]}) + (ro_ext <<< 3) + (ro_ext <<< 1);
  end

  // select multiplier operands
  always_comb begin
    mul_a = 17'(sl);
    mul_b = cfg_i.left_scale;
    case (state_q)
      S_RMUL: begin
        mul_a = 17'(sr);
        mul_b = cfg_i.right_scale;
      end
      S_AMUL: begin
        mul_a = 17'(dl_q) - 17'(dr_q);
        mul_b = cfg_i.angle_scale;
      end
      default: begin
        mul_a = 17'(sl);
        mul_b = cfg_i.left_scale;
      end
    endcase
  end

  // round half up, then saturate or clamp
  always_comb begin
    rsum = 34'(prod_q) + Half;
    rsh  = rsum >>> FractionBits;
    if (rsh > 34'sd32767) begin
      rsat = 16'sd32767;
    end else if (rsh < -34'sd32768) begin
      rsat = -16'sd32768;
    end else begin
      rsat = rsh[15:0];
    end
    if (rsh > 34'(ANGLE_LIMIT)) begin
      rclamp = 11'(ANGLE_LIMIT);
    end else if (rsh < -34'(ANGLE_LIMIT)) begin
      rclamp = -11'(ANGLE_LIMIT);
    end else begin
      rclamp = rsh[10:0];
    end
  end

  // sequence the work of one line
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.status == ST_OK) ? S_LMUL : S_EMIT;
        end
      end
      S_LMUL:   state_d = S_RMUL;
      S_RMUL:   state_d = S_RCAP;
      S_RCAP:   state_d = S_AMUL;
      S_AMUL:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    prod_q <= mul_a * mul_b;
    if (state_q == S_RMUL) begin
      dl_q <= rsat;
    end
    if (state_q == S_RCAP) begin
      dr_q <= rsat;
    end
  end

  // hold the last good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q[0]    <= '0;
      lg_q[1]    <= '0;
      lg_q[2]    <= '0;
      lg_q[3]    <= '0;
      lg_q[4]    <= '0;
      lg_angle_q <= '0;
    end else if (state_q == S_COMMIT) begin
      lg_q[0]    <= job_q.frame_id;
      lg_q[1]    <= job_q.left_reading;
      lg_q[2]    <= job_q.right_reading;
      lg_q[3]    <= dl_q;
      lg_q[4]    <= dr_q;
      lg_angle_q <= rclamp;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && out_free) begin
      status_o         <= job_q.status;
      frame_id_o       <= lg_q[0];
      left_reading_o   <= lg_q[1];
      right_reading_o  <= lg_q[2];
      left_distance_o  <= lg_q[3];
      right_distance_o <= lg_q[4];
      steer_angle_o    <= lg_angle_q;
    end
  end

endmodule

### hw/rtl/xor_checked_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// xor_checked_sensor_frame_decoder
// Decodes checksummed text lines into scaled distance and steering words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one character per
//   word; newline closes a line. Each line gives exactly one result word on
//   the output channel (out_valid_o/out_ready_i): status plus six values.
//   A non-newline character is parsed in the cycle it is taken, so bytes may
//   arrive back to back. A newline hands the line to a two-entry queue; the
//   arithmetic side then steps a good line through S_LMUL, S_RMUL, S_RCAP,
//   S_AMUL, S_COMMIT and S_EMIT (three products through one 17x16
//   multiplier, each registered) and sends an error line straight to S_EMIT.
//   Input stalls only while the queue holds two lines.
//   The configuration channel (cfg_valid_i/cfg_ready_o) is always ready;
//   write it only while no line is in flight.
//   Reset clears the line state, the queue, the output valid flag and the
//   last good frame, and loads the default offsets and unity scales.
//   A stalled receiver holds the output word; work behind it waits in the
//   queue and then at the input.
// ----------------------------------------------------------------------------
module xor_checked_sensor_frame_decoder #(
  parameter int unsigned FrameBufferBytes = xcsfd_pkg::FRAME_BUFFER_BYTES,
  parameter int unsigned FractionBits     = xcsfd_pkg::FRACTION_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [15:0] frame_id_o,
  output logic signed [15:0] left_reading_o,
  output logic signed [15:0] right_reading_o,
  output logic signed [15:0] left_distance_o,
  output logic signed [15:0] right_distance_o,
  output logic signed [10:0] steer_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import xcsfd_pkg::*;

  cfg_t cfg_q;
  job_t push_job, q_job;
  logic push, q_full, q_valid, pop, accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign accept      = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_bias   <= '0;
      cfg_q.right_bias  <= '0;
      cfg_q.left_scale  <= 16'sd4096;
      cfg_q.right_scale <= 16'sd4096;
      cfg_q.angle_scale <= 16'sd4096;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEFT_BIAS:   cfg_q.left_bias   <= cfg_data_i[7:0];
        CFG_RIGHT_BIAS:  cfg_q.right_bias  <= cfg_data_i[7:0];
        CFG_LEFT_SCALE:  cfg_q.left_scale  <= cfg_data_i;
        CFG_RIGHT_SCALE: cfg_q.right_scale <= cfg_data_i;
        CFG_ANGLE_SCALE: cfg_q.angle_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  xcsfd_front #(
    .FrameBufferBytes(FrameBufferBytes)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  xcsfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (q_job)
  );

  xcsfd_back #(
    .FractionBits(FractionBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .job_valid_i     (q_valid),
    .job_i           (q_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_id_o      (frame_id_o),
    .left_reading_o  (left_reading_o),
    .right_reading_o (right_reading_o),
    .left_distance_o (left_distance_o),
    .right_distance_o(right_distance_o),
    .steer_angle_o   (steer_angle_o)
  );

endmodule
